// ----- sv/twq_pkg.sv -----
// ----------------------------------------------------------------------------
// twq_pkg
// Shared constants, types and action codes for the timed wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package twq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int WAIT_BITS   = 16;

  // Index into the cell row, and a count that can hold the depth itself
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Fixed port field widths
  localparam int ACTION_W = 3;
  localparam int TID_W    = 8;
  localparam int WTIME_W  = 16;
  localparam int RCNT_W   = 5;
  localparam int QLEN_W   = 5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUT     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND    = 3'd4;

  // One queue entry
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [WAIT_BITS-1:0] ticks;
  } entry_t;

  // Control word for the cell row
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    entry_t           load_data;
  } chain_ctrl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_COUNT  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- sv/twq_if.sv -----
// ----------------------------------------------------------------------------
// twq_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface twq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] thread_id;
  logic [15:0] wait_time;
  logic [4:0] release_count;

  modport source (output valid, action, thread_id, wait_time, release_count,
                  input ready);
  modport sink   (input valid, action, thread_id, wait_time, release_count,
                  output ready);
endinterface

interface twq_rsp_if;
  logic       valid;
  logic       ready;
  logic       released_valid;
  logic [7:0] released_id;
  logic       timed_out;
  logic       found;
  logic       status;
  logic [4:0] queue_length;
  logic       last;

  modport source (output valid, released_valid, released_id, timed_out, found,
                  status, queue_length, last,
                  input ready);
  modport sink   (input valid, released_valid, released_id, timed_out, found,
                  status, queue_length, last,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/timed_wait_queue_unit.sv -----
// ----------------------------------------------------------------------------
// timed_wait_queue_unit
// FIFO of waiting thread ids with per-entry timeouts, built as a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  words          notes
//   -------  ---  -------------  ---------------------------------------------
//   req      in   one per action action, thread_id, wait_time, release_count
//   rsp      out  1..16 per req  released id / flags, queue_length, last
//
// Put and unused actions go straight to the closing word; release, remove and
// find make one pass over the entries; tick makes a counting pass, then the
// working pass. Release and tick send a closing word only when nothing leaves.
// Unless stalled, a pass pops the head cell once per cycle, reinserting kept entries.
// A result word not yet taken stalls the next drop word or the closing word.
// Synchronous reset empties the queue; no clearing pass is needed.
//
// ----------------------------------------------------------------------------
`default_nettype none

module timed_wait_queue_unit (
  input wire logic clk,
  input wire logic rst,
  twq_req_if.sink   req,
  twq_rsp_if.source rsp
);
  import twq_pkg::*;

  state_t                state;
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      remaining;
  logic [CNT_W-1:0]      kept;
  logic [CNT_W-1:0]      drops;
  logic [CNT_W-1:0]      final_len;
  logic [ACTION_W-1:0]   act;
  logic [ID_BITS-1:0]    key;
  logic                  hit;
  logic                  full_err;
  logic                  emitted;

  entry_t                head;
  chain_ctrl_t           ctrl;

  logic                  accept;
  logic                  put_now;
  logic                  match;
  logic                  expire;
  logic                  keep;
  logic [WAIT_BITS-1:0]  new_ticks;
  logic                  out_free;
  logic                  drop_word;
  logic                  step;
  logic                  emit_drop;
  logic                  emit_done;
  logic [CNT_W-1:0]      rel_drops;
  logic [CNT_W-1:0]      ins_pos;

  twq_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign put_now   = accept && (req.action == ACT_PUT) &&
                     (occupancy < CNT_W'(QUEUE_DEPTH));

  // Release count clipped to the current length
  assign rel_drops = (int'(req.release_count) < int'(occupancy)) ?
                     CNT_W'(req.release_count) : occupancy;

  // Head cell decisions
  assign match  = (head.id == key);
  assign expire = (head.ticks == WAIT_BITS'(1));

  always_comb begin
    keep      = 1'b1;
    new_ticks = head.ticks;
    if (state == ST_SCAN) begin
      case (act)
        ACT_RELEASE: keep = (drops == '0);
        ACT_TICK: begin
          keep = !expire;
          if (head.ticks != '0) begin
            new_ticks = head.ticks - WAIT_BITS'(1);
          end
        end
        ACT_REMOVE:  keep = !match;
        default:     keep = 1'b1;
      endcase
    end
  end

  // Only release and tick hand dropped entries out as result words
  assign drop_word = (act == ACT_RELEASE) || (act == ACT_TICK);

  assign out_free  = !rsp.valid || rsp.ready;
  assign step      = (remaining != '0) &&
                     ((state == ST_COUNT) ||
                      ((state == ST_SCAN) && (keep || !drop_word || out_free)));
  assign emit_drop = step && (state == ST_SCAN) && !keep && drop_word;
  assign emit_done = (state == ST_FINISH) && out_free;

  // Kept entries land just past the unprocessed ones
  assign ins_pos = remaining + kept - CNT_W'(1);

  // Cell row control
  always_comb begin
    ctrl.shift = step;
    ctrl.load  = put_now || (step && keep);
    if (put_now) begin
      ctrl.load_idx        = occupancy[IDX_W-1:0];
      ctrl.load_data.id    = ID_BITS'(req.thread_id);
      ctrl.load_data.ticks = WAIT_BITS'(req.wait_time);
    end else begin
      ctrl.load_idx        = ins_pos[IDX_W-1:0];
      ctrl.load_data.id    = head.id;
      ctrl.load_data.ticks = new_ticks;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      remaining <= '0;
      kept      <= '0;
      drops     <= '0;
      final_len <= '0;
      act       <= ACT_PUT;
      hit       <= 1'b0;
      full_err  <= 1'b0;
      emitted   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            act       <= req.action;
            remaining <= occupancy;
            kept      <= '0;
            drops     <= '0;
            hit       <= 1'b0;
            full_err  <= 1'b0;
            emitted   <= 1'b0;
            case (req.action)
              ACT_PUT: begin
                if (put_now) begin
                  occupancy <= occupancy + CNT_W'(1);
                end else begin
                  full_err <= 1'b1;
                end
                state <= ST_FINISH;
              end
              ACT_RELEASE: begin
                drops     <= rel_drops;
                final_len <= occupancy - rel_drops;
                state     <= ST_SCAN;
              end
              ACT_TICK:                state <= ST_COUNT;
              ACT_REMOVE, ACT_FIND:    state <= ST_SCAN;
              default:                 state <= ST_FINISH;
            endcase
          end
        end
        ST_COUNT: begin
          // Rotate once unchanged, counting entries that will expire
          if (remaining == '0) begin
            remaining <= kept;
            kept      <= '0;
            final_len <= kept - drops;
            state     <= ST_SCAN;
          end else if (step) begin
            remaining <= remaining - CNT_W'(1);
            kept      <= kept + CNT_W'(1);
            if (expire) begin
              drops <= drops + CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (remaining == '0) begin
            occupancy <= kept;
            if (((act == ACT_RELEASE) || (act == ACT_TICK)) && emitted) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_FINISH;
            end
          end else if (step) begin
            remaining <= remaining - CNT_W'(1);
            if (keep) begin
              kept <= kept + CNT_W'(1);
            end else begin
              drops   <= drops - CNT_W'(1);
              emitted <= 1'b1;
            end
            if (match) begin
              hit <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the key with the request word
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= ID_BITS'(req.thread_id);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit_drop || emit_done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_drop) begin
      rsp.released_valid <= 1'b1;
      rsp.released_id    <= TID_W'(head.id);
      rsp.timed_out      <= (act == ACT_TICK);
      rsp.found          <= 1'b0;
      rsp.status         <= 1'b0;
      rsp.queue_length   <= QLEN_W'(final_len);
      rsp.last           <= (drops == CNT_W'(1));
    end else if (emit_done) begin
      rsp.released_valid <= 1'b0;
      rsp.released_id    <= '0;
      rsp.timed_out      <= 1'b0;
      rsp.found          <= hit && ((act == ACT_REMOVE) || (act == ACT_FIND));
      rsp.status         <= full_err;
      rsp.queue_length   <= QLEN_W'(occupancy);
      rsp.last           <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/twq_cell.sv -----
// ----------------------------------------------------------------------------
// twq_cell
// One queue slot: loads a new entry, takes its right neighbor's entry, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module twq_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire logic           load,
  input  wire twq_pkg::entry_t nbr,
  input  wire twq_pkg::entry_t load_data,
  output      twq_pkg::entry_t entry
);
  import twq_pkg::*;

  // Load wins over shift: the insert point is the slot being refilled
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_data;
    end else if (shift) begin
      entry <= nbr;
    end
  end

endmodule

`default_nettype wire

// ----- sv/twq_chain.sv -----
// ----------------------------------------------------------------------------
// twq_chain
// Row of queue cells. Shift moves every entry one slot toward the head;
// load writes one slot chosen by index. Slot 0 is the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module twq_chain (
  input  wire logic                clk,
  input  wire twq_pkg::chain_ctrl_t ctrl,
  output      twq_pkg::entry_t     head
);
  import twq_pkg::*;

  entry_t cells [QUEUE_DEPTH];
  entry_t nbrs  [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    // Tail slot takes a blank word on shift; it is refilled by load if kept
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign nbrs[g] = '0;
    end else begin : g_mid
      assign nbrs[g] = cells[g+1];
    end

    twq_cell u_cell (
      .clk       (clk),
      .shift     (ctrl.shift),
      .load      (ctrl.load && (ctrl.load_idx == IDX_W'(g))),
      .nbr       (nbrs[g]),
      .load_data (ctrl.load_data),
      .entry     (cells[g])
    );
  end

  assign head = cells[0];

endmodule

`default_nettype wire

// ----- sv/twq_checker.sv -----
// ----------------------------------------------------------------------------
// twq_checker
// Port-level checks on the timed wait queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       released_valid,
  input wire logic [7:0] released_id,
  input wire logic       timed_out,
  input wire logic       found,
  input wire logic       status,
  input wire logic [4:0] queue_length,
  input wire logic       last
);
  import twq_pkg::*;

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(released_id) &&
      $stable(released_valid) && $stable(last) && $stable(queue_length))
    else $error("result word changed while stalled");

  // More words of the same request follow: no new request may be taken
  a_no_req_mid_burst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !last |=> !req_ready)
    else $error("request accepted before last result word");

  // A refused put carries no id and no match
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> !released_valid && !found && !timed_out && last)
    else $error("full status mixed with other flags");

  // Length never exceeds the queue depth, and a timeout always comes with an id
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(queue_length) <= QUEUE_DEPTH) && (!timed_out || released_valid))
    else $error("queue length or timeout flag out of range");

endmodule

bind timed_wait_queue_unit twq_checker u_twq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .released_valid (rsp.released_valid),
  .released_id    (rsp.released_id),
  .timed_out      (rsp.timed_out),
  .found          (rsp.found),
  .status         (rsp.status),
  .queue_length   (rsp.queue_length),
  .last           (rsp.last)
);

`default_nettype wire

// ----- tb/twq_step_checker.sv -----
// ----------------------------------------------------------------------------
// twq_step_checker
// Watches the request and result channels of the timed wait queue. It keeps
// its own copy of the queue, works out the result words of every accepted
// request, and compares each accepted result word with the oldest one due.
// ----------------------------------------------------------------------------
module twq_step_checker (
  input  logic clk,
  input  logic rst,
  twq_req_if   req,
  twq_rsp_if   rsp,
  output int   fail_count,
  output int   pending_words
);
  import twq_pkg::*;

  // One result word as it should appear on the result channel
  typedef struct packed {
    logic              released_valid;
    logic [TID_W-1:0]  released_id;
    logic              timed_out;
    logic              found;
    logic              status;
    logic [QLEN_W-1:0] queue_length;
    logic              last;
  } rsp_word_t;

  // Shadow copy of the queue, oldest entry at index 0
  logic [ID_BITS-1:0]   shadow_id   [QUEUE_DEPTH];
  logic [WAIT_BITS-1:0] shadow_wait [QUEUE_DEPTH];
  int unsigned          shadow_len = 0;

  rsp_word_t due_words[$];
  int        mismatches = 0;

  function automatic string show_word(rsp_word_t w);
    return $sformatf("rel=%0b id=%02h tmo=%0b found=%0b status=%0b len=%0d last=%0b",
                     w.released_valid, w.released_id, w.timed_out, w.found,
                     w.status, w.queue_length, w.last);
  endfunction

  // Apply one request to the shadow queue and queue up its result words
  task automatic predict_step(input logic [ACTION_W-1:0] act,
                              input logic [TID_W-1:0]    tid,
                              input logic [WTIME_W-1:0]  wt,
                              input logic [RCNT_W-1:0]   rc);
    rsp_word_t            w;
    rsp_word_t            step_words[$];
    logic [ID_BITS-1:0]   key;
    logic [WAIT_BITS-1:0] t;
    int unsigned          n;
    int unsigned          kept;
    logic                 hit;
    key  = tid[ID_BITS-1:0];
    hit  = 1'b0;
    kept = 0;
    case (act)
      ACT_PUT: begin
        w = '0;
        if (shadow_len >= QUEUE_DEPTH) begin
          w.status = 1'b1;
        end else begin
          shadow_id[shadow_len]   = key;
          shadow_wait[shadow_len] = wt[WAIT_BITS-1:0];
          shadow_len++;
        end
        step_words.push_back(w);
      end
      ACT_RELEASE: begin
        n = (rc > shadow_len) ? shadow_len : rc;
        for (int i = 0; i < n; i++) begin
          w = '0;
          w.released_valid = 1'b1;
          w.released_id    = shadow_id[i];
          step_words.push_back(w);
        end
        for (int i = n; i < shadow_len; i++) begin
          shadow_id[i-n]   = shadow_id[i];
          shadow_wait[i-n] = shadow_wait[i];
        end
        shadow_len -= n;
      end
      ACT_TICK: begin
        // untimed entries stay as they are; expiring ones leave in order
        for (int i = 0; i < shadow_len; i++) begin
          t = shadow_wait[i];
          if (t != '0) begin
            t = t - 1'b1;
            if (t == '0) begin
              w = '0;
              w.released_valid = 1'b1;
              w.released_id    = shadow_id[i];
              w.timed_out      = 1'b1;
              step_words.push_back(w);
              continue;
            end
          end
          shadow_id[kept]   = shadow_id[i];
          shadow_wait[kept] = t;
          kept++;
        end
        shadow_len = kept;
      end
      ACT_REMOVE: begin
        // every matching entry goes
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_id[i] == key) begin
            hit = 1'b1;
            continue;
          end
          shadow_id[kept]   = shadow_id[i];
          shadow_wait[kept] = shadow_wait[i];
          kept++;
        end
        shadow_len = kept;
        w = '0;
        w.found = hit;
        step_words.push_back(w);
      end
      ACT_FIND: begin
        for (int i = 0; i < shadow_len; i++)
          if (shadow_id[i] == key) hit = 1'b1;
        w = '0;
        w.found = hit;
        step_words.push_back(w);
      end
      default: ;
    endcase
    // empty release or tick, and unused actions, still report the length
    if (step_words.size() == 0) step_words.push_back('0);
    foreach (step_words[k]) begin
      step_words[k].queue_length = QLEN_W'(shadow_len);
      step_words[k].last         = (k == step_words.size() - 1);
      due_words.push_back(step_words[k]);
    end
  endtask

  // Predict on every accepted request, compare every accepted result word
  always @(posedge clk) begin : watch
    rsp_word_t got;
    rsp_word_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        predict_step(req.action, req.thread_id, req.wait_time, req.release_count);
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.released_valid, rsp.released_id, rsp.timed_out, rsp.found,
                rsp.status, rsp.queue_length, rsp.last};
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result word with none due: expected nothing, actual %s",
                     $time, show_word(got));
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
              $display("%0t: result word mismatch: expected %s, actual %s",
                       $time, show_word(want), show_word(got));
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_words <= due_words.size();
  end

endmodule

// ----- tb/tb_timed_wait_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_timed_wait_queue_unit
// Drives the timed wait queue with directed corner cases and then random
// sequences of puts, ticks, releases, removes and finds, with random idle
// gaps on the request side and random stalls on the result side. A separate
// checker predicts and compares every result word; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_timed_wait_queue_unit;
  import twq_pkg::*;

  localparam int RANDOM_WORDS = 400;

  // Actions with no function; the block must leave the queue alone
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending_words;
  int   issued = 0;
  logic req_quiet = 1'b0;
  logic rsp_quiet = 1'b0;
  logic [TID_W-1:0] id_pool [8];

  twq_req_if req_ch ();
  twq_rsp_if rsp_ch ();

  timed_wait_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  twq_step_checker step_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Random field values at the port widths
  function automatic logic [TID_W-1:0] any_id();
    return TID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WTIME_W-1:0] any_wait();
    return WTIME_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [RCNT_W-1:0] any_count();
    return RCNT_W'($urandom_range(0, 31));
  endfunction

  // Ids come mostly from a small pool so that finds, removes and
  // duplicates hit often
  function automatic logic [TID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 7)];
    return TID_W'($urandom_range(0, 255));
  endfunction

  // Mostly short waits so that ticks expire entries
  function automatic logic [WTIME_W-1:0] pick_wait();
    case ($urandom_range(0, 9))
      0:       return '0;
      8:       return WTIME_W'($urandom_range(1, 64));
      9:       return WTIME_W'($urandom_range(0, 65535));
      default: return WTIME_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [RCNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2, 3, 4: return RCNT_W'($urandom_range(1, 4));
      5, 6, 7:    return RCNT_W'($urandom_range(5, 16));
      default:    return RCNT_W'($urandom_range(17, 31));
    endcase
  endfunction

  // Send one request word after a random idle gap
  task automatic issue_request(input logic [ACTION_W-1:0] act,
                               input logic [TID_W-1:0]    tid,
                               input logic [WTIME_W-1:0]  wt,
                               input logic [RCNT_W-1:0]   rc);
    int gap;
    if (issued % 40 == 0) req_quiet = ($urandom_range(0, 3) == 0);
    gap = req_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.thread_id     <= tid;
    req_ch.wait_time     <= wt;
    req_ch.release_count <= rc;
    do @(posedge clk); while (!req_ch.ready);
    issued++;
  endtask

  // Result side: random stall before taking each word
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 60 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      stall = rsp_quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      taken++;
    end
  end

  // Stimulus
  initial begin : stimulus
    int directed;
    logic [TID_W-1:0] tid;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_PUT;
    req_ch.thread_id     <= '0;
    req_ch.wait_time     <= '0;
    req_ch.release_count <= '0;
    foreach (id_pool[k]) id_pool[k] = TID_W'($urandom_range(0, 255));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty queue: release past the length, tick with nothing to free
    issue_request(ACT_RELEASE, 8'h00, 16'h0000, 5'd16);
    issue_request(ACT_TICK,    8'hFF, 16'hFFFF, 5'd31);
    issue_request(ACT_FIND,    8'h00, 16'h0000, 5'd0);
    issue_request(ACT_REMOVE,  8'h00, 16'h0000, 5'd0);
    for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
      issue_request(ACTION_W'(a), any_id(), any_wait(), any_count());
    // Untimed, longest wait, one-tick and two-tick entries, and a duplicate
    issue_request(ACT_PUT, 8'h00, 16'h0000, 5'd0);
    issue_request(ACT_PUT, 8'hFF, 16'hFFFF, 5'd31);
    issue_request(ACT_PUT, 8'hAA, 16'h0001, 5'd0);
    issue_request(ACT_PUT, 8'h55, 16'h0002, 5'd0);
    issue_request(ACT_PUT, 8'hAA, 16'h0000, 5'd0);
    issue_request(ACT_FIND, 8'hAA, 16'h0000, 5'd0);
    issue_request(ACT_FIND, 8'h12, 16'h0000, 5'd0);
    issue_request(ACT_TICK, 8'h00, 16'h0000, 5'd0);
    // Remove takes the untimed duplicate; the second remove misses
    issue_request(ACT_REMOVE, 8'hAA, 16'h0000, 5'd0);
    issue_request(ACT_REMOVE, 8'hAA, 16'h0000, 5'd0);
    issue_request(ACT_TICK, 8'h00, 16'h0000, 5'd0);
    // Release of zero on a non-empty queue, then one clipped to the length
    issue_request(ACT_RELEASE, 8'h00, 16'h0000, 5'd0);
    issue_request(ACT_RELEASE, 8'h00, 16'h0000, 5'd31);
    directed = issued;

    // Random episodes
    while (issued < directed + RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2:
          repeat ($urandom_range(4, 18))
            issue_request(ACT_PUT, pick_id(), pick_wait(), any_count());
        3, 4:
          repeat ($urandom_range(1, 5))
            issue_request(ACT_TICK, any_id(), any_wait(), any_count());
        5: issue_request(ACT_RELEASE, any_id(), any_wait(), pick_count());
        6: issue_request(ACT_REMOVE, pick_id(), any_wait(), any_count());
        7: issue_request(ACT_FIND, pick_id(), any_wait(), any_count());
        8:
          // noise: any action code with arbitrary fields
          repeat ($urandom_range(1, 4))
            issue_request(ACTION_W'($urandom_range(0, 7)), any_id(), any_wait(),
                          any_count());
        default: begin
          tid = pick_id();
          issue_request(ACT_PUT,    tid, pick_wait(), any_count());
          issue_request(ACT_FIND,   tid, any_wait(), any_count());
          issue_request(ACT_REMOVE, tid, any_wait(), any_count());
          issue_request(ACT_FIND,   tid, any_wait(), any_count());
        end
      endcase
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow a little extra time for stray words
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
